@@ rtl/timestamp_line_tracker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Timestamp line tracker assertion macros
// Shared concurrent assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_LINE_TRACKER_UNIT_MACROS_SVH
`define TIMESTAMP_LINE_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define TLTU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLTU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tltu_pkg.sv @@
// ----------------------------------------------------------------------------
// Timestamp line tracker package
// Word widths, mode codes and default sizes shared by the tracker RTL.
// ----------------------------------------------------------------------------
package tltu_pkg;

  localparam int MODE_W        = 2;
  localparam int TIME_W        = 32;
  localparam int LINE_W        = 8;
  localparam int MAX_LINES_DEF = 256;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

endpackage

@@ rtl/tltu_if.sv @@
// ----------------------------------------------------------------------------
// Timestamp line tracker channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface tltu_item_if;
  import tltu_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output mode, output time_ms, input ready);
  modport sink   (input valid, input mode, input time_ms, output ready);
endinterface

interface tltu_result_if;
  import tltu_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_index;

  modport source (output valid, output line_index, input ready);
  modport sink   (input valid, input line_index, output ready);
endinterface

@@ rtl/tltu_ram.sv @@
// ----------------------------------------------------------------------------
// Timestamp line tracker RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tltu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ rtl/tltu_cell.sv @@
// ----------------------------------------------------------------------------
// Timestamp line tracker search cell
// One halving step of the upper-bound search: probe the middle entry of the
// incoming window and hand the narrowed window to the next cell.
// ----------------------------------------------------------------------------
module tltu_cell #(
  parameter int CW = 9,
  parameter int AW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [CW-1:0]               in_first,
  input  logic [CW-1:0]               in_len,
  input  logic [tltu_pkg::TIME_W-1:0] pos,
  input  logic [tltu_pkg::TIME_W-1:0] rd_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output logic                        out_valid,
  output logic [CW-1:0]               out_first,
  output logic [CW-1:0]               out_len
);
  import tltu_pkg::*;

  logic [CW-1:0] half_in;
  logic [CW-1:0] probe_in;
  logic          pend;
  logic [CW-1:0] first;
  logic [CW-1:0] probe;
  logic [CW-1:0] half;
  logic [CW-1:0] len;

  assign half_in  = in_len >> 1;
  assign probe_in = in_first + half_in;
  assign rd_en    = in_valid && (in_len != '0);
  assign rd_addr  = probe_in[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend      <= rd_en;
      out_valid <= (in_valid && (in_len == '0)) || pend;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      first <= in_first;
      probe <= probe_in;
      half  <= half_in;
      len   <= in_len;
    end
    if (in_valid && (in_len == '0)) begin
      out_first <= in_first;
      out_len   <= '0;
    end else if (pend) begin
      if (!(pos < rd_data)) begin
        out_first <= probe + CW'(1);
        out_len   <= len - half - CW'(1);
      end else begin
        out_first <= first;
        out_len   <= half;
      end
    end
  end
endmodule

@@ rtl/timestamp_line_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// Timestamp line tracker unit
// Line start table with current line tracking for a playback position.
// ----------------------------------------------------------------------------
// Clear and append words are done on acceptance. A position word on the fast
// path makes two table reads through the single RAM read port, then a compare,
// and then posts the result if the line changed. When the fast path misses, a
// chain of clog2(MAX_LINES+1) search cells runs the halving steps in turn; a
// cell with a non-empty window issues a table address and takes the registered
// read data, an empty one passes its window straight on. A search word goes
// through the accept step, the cells, a step to take the answer and one to
// post it, and may follow a fast path miss. One word is in work at a time; a
// finished result waits in the output register while the next word is taken.
`include "timestamp_line_tracker_unit_macros.svh"

module timestamp_line_tracker_unit #(
  parameter int MAX_LINES = tltu_pkg::MAX_LINES_DEF
) (
  input logic           clk,
  input logic           rst,
  tltu_item_if.sink     item,
  tltu_result_if.source result
);
  import tltu_pkg::*;

  localparam int AW    = $clog2(MAX_LINES);
  localparam int CW    = $clog2(MAX_LINES + 1);
  localparam int NSTEP = CW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FP1  = 3'd1;
  localparam logic [2:0] ST_FP2  = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     cur;
  logic [TIME_W-1:0] pos;
  logic              lo_ok;
  logic [AW-1:0]     next_line;
  logic              start_valid;
  logic              out_valid;
  logic [LINE_W-1:0] out_line;

  logic              accept;
  logic              fast_ok;
  logic              out_free;
  logic              emit;
  logic              start_next;
  logic              wr_en;
  logic              ctl_rd_en;
  logic [AW-1:0]     ctl_rd_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_data;
  logic [NSTEP:0]    rd_reqs;

  logic              step_valid [NSTEP+1];
  logic [CW-1:0]     step_first [NSTEP+1];
  logic [CW-1:0]     step_len   [NSTEP+1];
  logic [NSTEP-1:0]  cell_rd_en;
  logic [AW-1:0]     cell_rd_addr [NSTEP];

  assign item.ready        = (state == ST_IDLE);
  assign accept            = item.valid && item.ready;
  assign result.valid      = out_valid;
  assign result.line_index = out_line;
  assign out_free          = !out_valid || result.ready;
  assign emit              = (state == ST_RES) && (next_line != cur) && out_free;

  assign fast_ok = ((CW+1)'(cur) + (CW+1)'(2)) < (CW+1)'(cnt);
  assign wr_en   = accept && (item.mode == MODE_APPEND) && (cnt < CW'(MAX_LINES));

  assign start_next = (accept && (item.mode == MODE_QUERY) && !fast_ok) ||
                      ((state == ST_FP2) && !(lo_ok && (pos < rd_data)));

  always_comb begin
    ctl_rd_en   = 1'b0;
    ctl_rd_addr = '0;
    if (accept && (item.mode == MODE_QUERY) && fast_ok) begin
      ctl_rd_en   = 1'b1;
      ctl_rd_addr = cur + AW'(1);
    end else if (state == ST_FP1) begin
      ctl_rd_en   = 1'b1;
      ctl_rd_addr = cur + AW'(2);
    end
  end

  always_comb begin
    rd_en   = ctl_rd_en;
    rd_addr = ctl_rd_addr;
    for (int i = 0; i < NSTEP; i++) begin
      rd_en   = rd_en | cell_rd_en[i];
      rd_addr = rd_addr | (cell_rd_en[i] ? cell_rd_addr[i] : '0);
    end
  end

  assign rd_reqs = {ctl_rd_en, cell_rd_en};

  tltu_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_LINES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (item.time_ms),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign step_valid[0] = start_valid;
  assign step_first[0] = '0;
  assign step_len[0]   = cnt;

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    tltu_cell #(
      .CW (CW),
      .AW (AW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (step_valid[g]),
      .in_first  (step_first[g]),
      .in_len    (step_len[g]),
      .pos       (pos),
      .rd_data   (rd_data),
      .rd_en     (cell_rd_en[g]),
      .rd_addr   (cell_rd_addr[g]),
      .out_valid (step_valid[g+1]),
      .out_first (step_first[g+1]),
      .out_len   (step_len[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      cur         <= '0;
      start_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      start_valid <= start_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.mode)
              MODE_CLEAR: begin
                cnt <= '0;
                cur <= '0;
              end
              MODE_APPEND: begin
                if (cnt < CW'(MAX_LINES)) begin
                  cnt <= cnt + CW'(1);
                end
              end
              MODE_QUERY: begin
                if (fast_ok) begin
                  state <= ST_FP1;
                end else begin
                  state <= ST_SRCH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FP1: begin
          state <= ST_FP2;
        end
        ST_FP2: begin
          if (lo_ok && (pos < rd_data)) begin
            state <= ST_RES;
          end else begin
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (step_valid[NSTEP]) begin
            state <= ST_RES;
          end
        end
        ST_RES: begin
          if (next_line == cur) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            cur   <= next_line;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= item.time_ms;
    end
    if (state == ST_FP1) begin
      lo_ok <= !(pos < rd_data);
    end
    if ((state == ST_FP2) && lo_ok && (pos < rd_data)) begin
      next_line <= cur + AW'(1);
    end
    if ((state == ST_SRCH) && step_valid[NSTEP]) begin
      next_line <= (step_first[NSTEP] == '0) ? '0 : AW'(step_first[NSTEP] - CW'(1));
    end
    if (emit) begin
      out_line <= LINE_W'(next_line);
    end
  end

  `TLTU_ASSERT_IMP(a_one_reader, clk, rst, 1'b1, $onehot0(rd_reqs), "table read port shared")
  `TLTU_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(MAX_LINES), "entry count overflow")
  `TLTU_ASSERT_IMP(a_line_in_table, clk, rst, 1'b1, (cur == '0) || (CW'(cur) < cnt),
    "current line beyond table")
  `TLTU_ASSERT_IMP(a_chain_in_search, clk, rst, step_valid[NSTEP], state == ST_SRCH,
    "search result outside search")
  `TLTU_ASSERT_NXT(a_emit_change, clk, rst,
    (state == ST_RES) && (next_line != cur) && out_free,
    out_valid && (cur == $past(next_line)), "changed line not posted")
endmodule

@@ dv/tltu_line_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timestamp line tracker checker
// Watches the input and result channels of the tracker. It keeps its own
// line start table, entry count and current line, works out the new line for
// every position word, and queues the line index whenever it changes. Each
// result word is compared with the oldest queued index.
// ----------------------------------------------------------------------------
module tltu_line_checker #(
  parameter int MAX_LINES = tltu_pkg::MAX_LINES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  tltu_item_if   item,
  tltu_result_if result,
  output int     mismatch_count,
  output int     pending
);
  import tltu_pkg::*;

  logic [TIME_W-1:0] start_ms [MAX_LINES];
  int unsigned       line_count;
  int unsigned       cur_line;
  logic [LINE_W-1:0] line_due_q [$];

  initial begin
    mismatch_count = 0;
    pending        = 0;
    line_count     = 0;
    cur_line       = 0;
  end

  // upper bound: first entry strictly above pos, fixed halving over the table
  function automatic int unsigned first_entry_above(logic [TIME_W-1:0] pos);
    int unsigned lo;
    int unsigned span;
    int unsigned half;
    int unsigned probe;
    lo   = 0;
    span = line_count;
    while (span > 0) begin
      half  = span / 2;
      probe = lo + half;
      if (probe < MAX_LINES && !(pos < start_ms[probe])) begin
        lo   = probe + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    return lo;
  endfunction

  function automatic void predict_line(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] t);
    int unsigned next_line;
    int unsigned above;
    case (mode)
      MODE_CLEAR: begin
        line_count = 0;
        cur_line   = 0;
      end
      MODE_APPEND: begin
        if (line_count < MAX_LINES) begin
          start_ms[line_count] = t;
          line_count++;
        end
      end
      MODE_QUERY: begin
        if (cur_line + 2 < line_count && t >= start_ms[cur_line + 1] &&
            t < start_ms[cur_line + 2]) begin
          next_line = cur_line + 1;
        end else begin
          above     = first_entry_above(t);
          next_line = (above == 0) ? 0 : above - 1;
        end
        if (next_line != cur_line) begin
          cur_line = next_line;
          line_due_q.push_back(next_line[LINE_W-1:0]);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    logic [LINE_W-1:0] due;
    if (rst) begin
      line_count = 0;
      cur_line   = 0;
      line_due_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (line_due_q.size() == 0) begin
          mismatch_count++;
          $display("%0t tltu_line_checker: line_index expected none actual %0d",
                   $time, result.line_index);
        end else begin
          due = line_due_q.pop_front();
          if (result.line_index !== due) begin
            mismatch_count++;
            $display("%0t tltu_line_checker: line_index expected %0d actual %0d",
                     $time, due, result.line_index);
          end
        end
      end
      if (item.valid && item.ready)
        predict_line(item.mode, item.time_ms);
    end
    pending = line_due_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timestamp line tracker testbench
// Drives clear, append and position words into the tracker: a directed
// opening on extremes, stray modes and an unsorted table, then sessions of
// ascending timestamp tables walked by rising positions, with jumps, exact
// hits, a full table and noise. Input words come in bursts with gaps, result
// words are stalled on a changing pattern, and the checker does the compare.
// ----------------------------------------------------------------------------
module tb_top;
  import tltu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  int          mismatches;
  int          lines_due;
  int          words_sent;
  int          burst_left;
  int          seg_left;
  int          ready_style;
  logic [31:0] ready_bits;

  tltu_item_if   item_ch ();
  tltu_result_if result_ch ();

  timestamp_line_tracker_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  tltu_line_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .result         (result_ch),
    .mismatch_count (mismatches),
    .pending        (lines_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: segments of full rate, rotating pattern and random stalls
  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_left    = $urandom_range(20, 80);
      ready_style = $urandom_range(0, 3);
      ready_bits  = $urandom | 32'h1;
    end else begin
      seg_left--;
    end
    case (ready_style)
      0: result_ch.ready = 1'b1;
      1: begin
        result_ch.ready = ready_bits[0];
        ready_bits      = {ready_bits[0], ready_bits[31:1]};
      end
      2: result_ch.ready = ($urandom_range(0, 3) == 0);
      default: result_ch.ready = ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 20);
      endcase
    end
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid   = 1'b0;
      item_ch.mode    = MODE_W'($urandom);
      item_ch.time_ms = $urandom;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   = 1'b1;
    item_ch.mode    = m;
    item_ch.time_ms = t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    burst_left--;
    if (m != MODE_NONE) words_sent++;
  endtask

  // hold the sender until every queued line index has come back
  task automatic drain_lines();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (lines_due != 0) @(negedge clk);
  endtask

  initial begin
    int          n;
    int          q;
    int          k;
    int          kind;
    int          sessions;
    int          step_max;
    bit          big_done;
    logic [31:0] base;
    logic [31:0] t;
    logic [31:0] pos;
    logic [31:0] stamps [$];

    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.mode    = MODE_CLEAR;
    item_ch.time_ms = '0;
    result_ch.ready = 1'b0;
    words_sent      = 0;
    burst_left      = 0;
    seg_left        = 0;
    ready_style     = 0;
    ready_bits      = 32'h1;
    sessions        = 0;
    big_done        = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    send_word(MODE_CLEAR, 32'h0);
    send_word(MODE_QUERY, 32'd5);
    send_word(MODE_NONE, 32'hFFFF_FFFF);
    send_word(MODE_APPEND, 32'h0);
    send_word(MODE_APPEND, 32'd100);
    send_word(MODE_APPEND, 32'd200);
    send_word(MODE_APPEND, 32'd300);
    send_word(MODE_APPEND, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'd150);
    send_word(MODE_QUERY, 32'd250);
    send_word(MODE_QUERY, 32'd300);
    send_word(MODE_QUERY, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'h0);
    send_word(MODE_QUERY, 32'h0);
    send_word(MODE_QUERY, 32'hFFFF_FFFE);
    send_word(MODE_CLEAR, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'hFFFF_FFFF);
    send_word(MODE_APPEND, 32'd500);
    send_word(MODE_APPEND, 32'd100);
    send_word(MODE_APPEND, 32'd300);
    send_word(MODE_QUERY, 32'd200);
    send_word(MODE_QUERY, 32'd600);
    send_word(MODE_NONE, 32'h0);

    while (words_sent < 750) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(3, 12)) send_word(MODE_W'($urandom_range(0, 3)), $urandom);
      end else begin
        if (kind != 1) send_word(MODE_CLEAR, $urandom);
        if (!big_done && words_sent > 250) begin
          n        = MAX_LINES_DEF + $urandom_range(1, 3);
          big_done = 1'b1;
        end else begin
          n = $urandom_range(0, 20);
        end
        step_max = $urandom_range(1, 3000);
        case ($urandom_range(0, 3))
          0:       base = 32'h0;
          1:       base = $urandom_range(0, 1000);
          2:       base = 32'hFFFF_FFFF - n * step_max - $urandom_range(0, 100);
          default: base = $urandom_range(0, 32'h7FFF_FFFF);
        endcase
        stamps.delete();
        t = base;
        for (k = 0; k < n; k++) begin
          if (k < 2 && $urandom_range(0, 5) == 0) begin
            send_word(MODE_APPEND, 32'h0);
            stamps.push_back(32'h0);
          end else begin
            t = t + $urandom_range(0, step_max);
            send_word(MODE_APPEND, t);
            stamps.push_back(t);
          end
          if (kind == 2 && $urandom_range(0, 7) == 0) send_word(MODE_APPEND, $urandom);
        end
        q   = (n > MAX_LINES_DEF) ? 80 : $urandom_range(4, 30);
        pos = base;
        for (k = 0; k < q; k++) begin
          case ($urandom_range(0, 9))
            0: pos = $urandom;
            1: if (stamps.size() > 0) pos = stamps[$urandom_range(0, stamps.size() - 1)];
            2: pos = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            3: send_word(MODE_NONE, $urandom);
            default: pos = pos + $urandom_range(0, step_max);
          endcase
          send_word(MODE_QUERY, pos);
        end
        sessions++;
        if (sessions == 6) drain_lines();
      end
    end

    drain_lines();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && lines_due == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
